// ----- sv/plc_pkg.sv -----
package plc_pkg;

  localparam int CAL_POINTS_DEF = 8;

  localparam logic [11:0] DAC_MAX = 12'hFFF;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ADC   = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  localparam int KEY_W  = 17;
  localparam int DIFF_W = 18;
  localparam int PROD_W = 36;
  localparam int NUM_W  = 32;
  localparam int MAG_W  = NUM_W - 1;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         point_index;
    logic [9:0]         adc_code;
    logic signed [15:0] physical_value;
    logic [11:0]        dac_code;
  } item_in_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic signed [15:0] clamped_setpoint;
    logic               span_error;
  } item_out_t;

  typedef struct packed {
    logic [9:0]         adc;
    logic signed [15:0] phys;
    logic [11:0]        dac;
  } entry_t;

  typedef struct packed {
    logic load;
    logic write;
    logic step;
    logic take_pair;
    logic take_lo;
    logic take_hi;
    logic exact;
    logic diff;
    logic set_err;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_init;
    logic div_step;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic first;
    logic last;
    logic dx_zero;
    logic div_last;
  } stat_t;

endpackage

// ----- sv/plc_ctrl.sv -----
module plc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     op,
  input  plc_pkg::stat_t st,
  output plc_pkg::ctl_t  ctl,
  output logic           busy,
  output logic           done
);
  import plc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FETCH, S_SPAN, S_MUL1, S_MUL2, S_SUM, S_DINIT, S_DIV, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          if (op == OP_WRITE) begin
            ctl.write = 1'b1;
          end
          if (op == OP_ADC || op == OP_SET) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (st.eq) begin
          ctl.exact  = 1'b1;
          state_next = S_FIN;
        end else if (st.gt && st.first) begin
          ctl.take_lo = 1'b1;
          state_next  = S_FETCH;
        end else if (st.gt || st.last) begin
          ctl.take_pair = 1'b1;
          state_next    = S_SPAN;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_FETCH: begin
        ctl.take_hi = 1'b1;
        state_next  = S_SPAN;
      end
      S_SPAN: begin
        ctl.diff   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        if (st.dx_zero) begin
          ctl.set_err = 1'b1;
          state_next  = S_FIN;
        end else begin
          ctl.mul1   = 1'b1;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        ctl.mul2   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        ctl.sum    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        ctl.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_FIN);
    end
  end

endmodule

// ----- sv/plc_dpath.sv -----
module plc_dpath #(
  parameter int CAL_POINTS = plc_pkg::CAL_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  plc_pkg::item_in_t  cmd,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_data,
  input  plc_pkg::ctl_t      ctl,
  output plc_pkg::stat_t     st,
  output plc_pkg::item_out_t result
);
  import plc_pkg::*;

  localparam int IW    = (CAL_POINTS > 1) ? $clog2(CAL_POINTS) : 1;
  localparam int CNT_W = $clog2(MAG_W);

  function automatic logic signed [KEY_W-1:0] key_of(entry_t e, logic by_phys);
    logic signed [KEY_W-1:0] k;
    if (by_phys) begin
      k = {e.phys[15], e.phys};
    end else begin
      k = $signed({7'b0, e.adc});
    end
    return k;
  endfunction

  function automatic logic signed [KEY_W-1:0] val_of(entry_t e, logic by_phys);
    logic signed [KEY_W-1:0] v;
    if (by_phys) begin
      v = $signed({5'b0, e.dac});
    end else begin
      v = {e.phys[15], e.phys};
    end
    return v;
  endfunction

  entry_t mem [CAL_POINTS];
  entry_t rd;
  entry_t prev;
  entry_t lo;
  entry_t hi;

  logic signed [15:0]       lim;
  logic [1:0]               op_r;
  logic signed [KEY_W-1:0]  x;
  logic signed [15:0]       clamp_r;
  logic [IW-1:0]            idx;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] xd;
  logic signed [KEY_W-1:0]  yhi;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [NUM_W-1:0]  num;
  logic                     hit;
  logic                     err;
  logic signed [KEY_W-1:0]  hit_val;
  logic [MAG_W-1:0]         q;
  logic [DIFF_W-1:0]        dvs;
  logic [DIFF_W-1:0]        rem;
  logic                     neg;
  logic [CNT_W-1:0]         cnt;

  logic                     by_phys;
  logic                     conv;
  logic signed [15:0]       clamp_v;
  logic [IW-1:0]            waddr;
  logic [IW-1:0]            raddr;
  logic signed [KEY_W-1:0]  k_rd;
  logic signed [KEY_W-1:0]  kh;
  logic signed [KEY_W-1:0]  kl;
  logic signed [KEY_W-1:0]  vh;
  logic signed [KEY_W-1:0]  vl;
  logic [DIFF_W:0]          rem_sh;
  logic                     fits;
  logic signed [15:0]       sat_val;

  assign by_phys = (op_r == OP_SET);
  assign conv    = (op_r == OP_ADC) || (op_r == OP_SET);

  always_comb begin
    clamp_v = cmd.physical_value;
    if ((lim > 0 && clamp_v > lim) || (lim < 0 && clamp_v < lim)) begin
      clamp_v = lim;
    end
    if ((lim > 0 && clamp_v < 0) || (lim < 0 && clamp_v > 0)) begin
      clamp_v = '0;
    end
  end

  assign waddr = ({1'b0, cmd.point_index} >= 5'(CAL_POINTS)) ?
                 IW'(CAL_POINTS - 1) : cmd.point_index[IW-1:0];
  assign raddr = (ctl.load || st.last) ? ((ctl.load) ? '0 : idx) : IW'(idx + 1'b1);

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem[waddr] <= '{adc: cmd.adc_code, phys: cmd.physical_value, dac: cmd.dac_code};
    end
    rd <= mem[raddr];
  end

  assign k_rd = key_of(rd, by_phys);
  assign kh   = key_of(hi, by_phys);
  assign kl   = key_of(lo, by_phys);
  assign vh   = val_of(hi, by_phys);
  assign vl   = val_of(lo, by_phys);

  assign st.eq       = (k_rd == x);
  assign st.gt       = (k_rd > x);
  assign st.first    = (idx == '0);
  assign st.last     = (idx == IW'(CAL_POINTS - 1));
  assign st.dx_zero  = (dx == '0);
  assign st.div_last = (cnt == CNT_W'(MAG_W - 1));

  assign rem_sh = {rem, q[MAG_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= '0;
    end else if (cfg_we) begin
      lim <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r    <= cmd.op;
      idx     <= '0;
      hit     <= 1'b0;
      err     <= 1'b0;
      clamp_r <= clamp_v;
      if (cmd.op == OP_SET) begin
        x <= {clamp_v[15], clamp_v};
      end else begin
        x <= $signed({7'b0, cmd.adc_code});
      end
    end
    if (ctl.step) begin
      prev <= rd;
      idx  <= IW'(idx + 1'b1);
    end
    if (ctl.take_pair) begin
      lo <= prev;
      hi <= rd;
    end
    if (ctl.take_lo) begin
      lo <= rd;
    end
    if (ctl.take_hi) begin
      hi <= rd;
    end
    if (ctl.exact) begin
      hit     <= 1'b1;
      hit_val <= val_of(rd, by_phys);
    end
    if (ctl.diff) begin
      dx  <= DIFF_W'(kh - kl);
      dy  <= DIFF_W'(vh - vl);
      xd  <= DIFF_W'(x - kh);
      yhi <= vh;
    end
    if (ctl.set_err) begin
      err <= 1'b1;
    end
    if (ctl.mul1) begin
      p1 <= PROD_W'(dy * xd);
    end
    if (ctl.mul2) begin
      p2 <= PROD_W'(yhi * dx);
    end
    if (ctl.sum) begin
      num <= NUM_W'(p1 + p2);
    end
    if (ctl.div_init) begin
      q   <= num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
      dvs <= dx[DIFF_W-1] ? DIFF_W'(-dx) : dx;
      neg <= num[NUM_W-1] ^ dx[DIFF_W-1];
      rem <= '0;
      cnt <= '0;
    end
    if (ctl.div_step) begin
      cnt <= CNT_W'(cnt + 1'b1);
      if (fits) begin
        rem <= DIFF_W'(rem_sh - {1'b0, dvs});
        q   <= {q[MAG_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIFF_W-1:0];
        q   <= {q[MAG_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (by_phys) begin
      if (neg) begin
        sat_val = '0;
      end else if (q > MAG_W'(DAC_MAX)) begin
        sat_val = $signed({4'b0, DAC_MAX});
      end else begin
        sat_val = $signed({4'b0, q[11:0]});
      end
    end else begin
      if (!neg) begin
        sat_val = (q > MAG_W'(32767)) ? 16'sh7FFF : $signed(q[15:0]);
      end else begin
        sat_val = (q > MAG_W'(32768)) ? 16'sh8000 : $signed(16'(~q[15:0] + 1'b1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result.clamped_setpoint <= by_phys ? clamp_r : 16'sd0;
      result.span_error       <= conv && !hit && err;
      if (!conv || err) begin
        result.result_value <= '0;
      end else if (hit) begin
        result.result_value <= hit_val[15:0];
      end else begin
        result.result_value <= sat_val;
      end
    end
  end

endmodule

// ----- sv/piecewise_linear_calibration.sv -----
// A table write or an unused op goes straight to the finish state after start.
// A conversion scans one table entry per cycle; an exact match finishes after the scan,
// otherwise span differences, two multiplies, a sum and a restoring divide follow.
// Throughput: one command at a time; busy stays high until the result strobe (done).
// Reset (rst, synchronous) clears control and setpoint_limit; table contents stay undefined.
// The result is valid only while done is high; the receiver cannot stall.
module piecewise_linear_calibration #(
  parameter int CAL_POINTS = plc_pkg::CAL_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  plc_pkg::item_in_t  cmd,
  output logic               done,
  output plc_pkg::item_out_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);
  import plc_pkg::*;

  ctl_t  ctl;
  stat_t st;
  logic  cfg_we;

  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  plc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (cmd.op),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  plc_dpath #(
    .CAL_POINTS (CAL_POINTS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .st       (st),
    .result   (result)
  );

endmodule
